/* design/spp_pkg.sv */
// Shared types and constants for the stepper acceleration profile planner.
package spp_pkg;

    localparam int TSIZE_W = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_END_VELOCITY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCELERATION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_DELAY  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DELAY    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_INTERP  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_HIGH_CW  = 3'd5;

    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_ENTRY  = 1'b1;

    typedef struct packed {
        logic [31:0] total_steps;
        logic        direction;
    } item_t;

    typedef struct packed {
        logic               kind;
        logic               is_trapezoidal;
        logic [31:0]        accel_steps;
        logic [31:0]        cruise_steps;
        logic [31:0]        decel_steps;
        logic [31:0]        interp_factor;
        logic [TSIZE_W-1:0] table_size;
        logic               dir_level;
        logic [TSIZE_W-1:0] entry_index;
        logic [15:0]        delay_ticks;
        logic               last;
    } result_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_SHAPE,
        CMD_INTERP_DIV,
        CMD_INTERP_SET,
        CMD_TSIZE_DIV,
        CMD_TSIZE_SET,
        CMD_HEADER,
        CMD_ENTRY,
        CMD_REC_DIV,
        CMD_REC_UPD,
        CMD_NEXT_ENTRY
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic need_enlarge;
        logic tsize_zero;
        logic more_steps;
        logic last_entry;
    } dp_flags_t;

endpackage

/* design/spp_div.sv */
// Restoring serial divider, one quotient bit per cycle.
module spp_div
    import spp_pkg::*;
#(
    parameter int DW = 36
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic [DW-1:0] quotient,
    output logic          done
);
    localparam int CNT_W = $clog2(DW + 1);

    logic [DW-1:0]    q_reg;
    logic [DW-1:0]    r_reg;
    logic [DW-1:0]    d_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             active_reg;
    logic             done_reg;
    logic [DW:0]      rs;
    logic             ge;

    assign rs = {r_reg, q_reg[DW-1]};
    assign ge = rs >= {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                active_reg <= 1'b1;
                cnt_reg    <= CNT_W'(DW);
            end
            else if (active_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (active_reg)
        begin
            if (ge)
            begin
                r_reg <= DW'(rs - {1'b0, d_reg});
                q_reg <= {q_reg[DW-2:0], 1'b1};
            end
            else
            begin
                r_reg <= rs[DW-1:0];
                q_reg <= {q_reg[DW-2:0], 1'b0};
            end
        end
    end

    assign quotient = q_reg;
    assign done = done_reg;
endmodule

/* design/spp_datapath.sv */
// Datapath: configuration registers, profile arithmetic, recurrence and result register.
module spp_datapath
    import spp_pkg::*;
#(
    parameter int TABLE_MAX = 32,
    parameter int SCALE_BITS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  item_t                 item,
    input  cmd_t                  cmd,
    output dp_flags_t             status,
    output result_t               result,
    output logic                  result_strobe
);
    localparam int CW = 16 + SCALE_BITS;
    localparam int KW = CW + 2;
    localparam int DW = (KW + 2 > 34) ? KW + 2 : 34;
    localparam int TM_LOG = $clog2(TABLE_MAX);
    localparam int RS = 32 + TM_LOG;
    localparam logic [32:0] RM =
        33'(((65'd1 << RS) + 65'(TABLE_MAX) - 65'd1) / 65'(TABLE_MAX));
    localparam logic [16:0] RM_LO = RM[16:0];
    localparam logic [15:0] RM_HI = RM[32:17];

    logic [15:0]        ev_reg;
    logic [23:0]        acc_reg;
    logic [15:0]        first_reg;
    logic [15:0]        min_reg;
    logic [7:0]         base_reg;
    logic               cw_reg;

    logic [31:0]        total_reg;
    logic               dir_reg;
    logic               trap_reg;
    logic [31:0]        up_reg;
    logic [31:0]        cruise_reg;
    logic [31:0]        down_reg;
    logic [31:0]        interp_reg;
    logic [TSIZE_W-1:0] tsize_reg;
    logic               level_reg;
    logic [CW-1:0]      cur_reg;
    logic [KW-1:0]      k_reg;
    logic [TSIZE_W-1:0] e_reg;
    logic [31:0]        i_reg;
    logic               frozen_reg;
    logic [48:0]        prod_lo_reg;
    result_t            result_reg;
    logic               strobe_reg;

    logic               div_start;
    logic [DW-1:0]      div_dividend;
    logic [DW-1:0]      div_divisor;
    logic [DW-1:0]      q;
    logic               div_done;
    logic [23:0]        acc_eff;
    logic [31:0]        a_steps;
    logic [CW-1:0]      floor_d;
    logic [CW-1:0]      dec;
    logic [CW-1:0]      nx_raw;
    logic [CW-1:0]      nx;
    logic [13:0]        limit;
    logic [31:0]        ix;
    logic [47:0]        prod_hi;
    logic [64:0]        prod_sum;

    assign acc_eff = (acc_reg == '0) ? 24'd1 : acc_reg;
    assign a_steps = q[31:0];
    assign floor_d = CW'(min_reg) << SCALE_BITS;
    assign dec     = q[CW-1:0];
    assign nx_raw  = cur_reg - dec;
    assign nx      = (nx_raw < floor_d) ? floor_d : nx_raw;
    assign limit   = 14'(TABLE_MAX) * {6'd0, interp_reg[7:0]};
    assign ix       = up_reg + 32'(TABLE_MAX - 1);
    assign prod_hi  = 48'(ix) * 48'(RM_HI);
    assign prod_sum = 65'(prod_lo_reg) + (65'(prod_hi) << 17);

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        unique case (cmd)
            CMD_LOAD:
            begin
                div_start    = 1'b1;
                div_dividend = DW'(ev_reg) * DW'(ev_reg);
                div_divisor  = DW'({acc_eff, 1'b0});
            end
            CMD_TSIZE_DIV:
            begin
                div_start    = 1'b1;
                div_dividend = DW'(up_reg) + DW'(interp_reg) - DW'(1);
                div_divisor  = DW'(interp_reg);
            end
            CMD_REC_DIV:
            begin
                div_start    = 1'b1;
                div_dividend = DW'({cur_reg, 1'b0});
                div_divisor  = DW'({k_reg, 2'b00}) + DW'(1);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    spp_div #(.DW(DW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (q),
        .done     (div_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_reg    <= 16'd1000;
            acc_reg   <= 24'd1000;
            first_reg <= 16'd65535;
            min_reg   <= 16'd1000;
            base_reg  <= 8'd1;
            cw_reg    <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_END_VELOCITY: ev_reg    <= cfg_data[15:0];
                REG_ACCELERATION: acc_reg   <= cfg_data[23:0];
                REG_FIRST_DELAY:  first_reg <= cfg_data[15:0];
                REG_MIN_DELAY:    min_reg   <= cfg_data[15:0];
                REG_BASE_INTERP:  base_reg  <= cfg_data[7:0];
                REG_DIR_HIGH_CW:  cw_reg    <= cfg_data[0];
                default:          ev_reg    <= ev_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= (cmd == CMD_HEADER) || (cmd == CMD_ENTRY);
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd)
            CMD_LOAD:
            begin
                total_reg <= item.total_steps;
                dir_reg   <= item.direction;
            end
            CMD_SHAPE:
            begin
                if ({a_steps, 1'b0} >= {1'b0, total_reg})
                begin
                    trap_reg   <= 1'b0;
                    up_reg     <= {1'b0, total_reg[31:1]};
                    down_reg   <= total_reg - {1'b0, total_reg[31:1]};
                    cruise_reg <= '0;
                end
                else
                begin
                    trap_reg   <= 1'b1;
                    up_reg     <= a_steps;
                    down_reg   <= a_steps;
                    cruise_reg <= total_reg - {a_steps[30:0], 1'b0};
                end
                interp_reg <= (base_reg == '0) ? 32'd1 : 32'(base_reg);
                level_reg  <= cw_reg ? (dir_reg == 1'b0) : (dir_reg == 1'b1);
            end
            CMD_INTERP_DIV:
            begin
                prod_lo_reg <= 49'(ix) * 49'(RM_LO);
            end
            CMD_INTERP_SET:
            begin
                interp_reg <= 32'(prod_sum >> RS);
            end
            CMD_TSIZE_SET:
            begin
                tsize_reg <= (q > DW'(TABLE_MAX)) ? TSIZE_W'(TABLE_MAX) : q[TSIZE_W-1:0];
            end
            CMD_HEADER:
            begin
                cur_reg    <= CW'(first_reg) << SCALE_BITS;
                k_reg      <= KW'(1);
                e_reg      <= '0;
                frozen_reg <= 1'b0;
                result_reg <= '{kind: KIND_HEADER, is_trapezoidal: trap_reg,
                               accel_steps: up_reg, cruise_steps: cruise_reg,
                               decel_steps: down_reg, interp_factor: interp_reg,
                               table_size: tsize_reg, dir_level: level_reg,
                               entry_index: '0, delay_ticks: '0,
                               last: (tsize_reg == '0)};
            end
            CMD_ENTRY:
            begin
                i_reg      <= '0;
                result_reg <= '{kind: KIND_ENTRY, is_trapezoidal: trap_reg,
                               accel_steps: up_reg, cruise_steps: cruise_reg,
                               decel_steps: down_reg, interp_factor: interp_reg,
                               table_size: tsize_reg, dir_level: level_reg,
                               entry_index: e_reg,
                               delay_ticks: cur_reg[CW-1:SCALE_BITS],
                               last: status.last_entry};
            end
            CMD_REC_UPD:
            begin
                if (nx == cur_reg && (dec == '0 || cur_reg == floor_d))
                begin
                    frozen_reg <= 1'b1;
                end
                cur_reg <= nx;
                k_reg   <= k_reg + 1'b1;
                i_reg   <= i_reg + 1'b1;
            end
            CMD_NEXT_ENTRY:
            begin
                e_reg <= e_reg + 1'b1;
            end
            default:
            begin
                total_reg <= total_reg;
            end
        endcase
    end

    assign status.div_done     = div_done;
    assign status.need_enlarge = up_reg > 32'(limit);
    assign status.tsize_zero   = tsize_reg == '0;
    assign status.more_steps   = (i_reg < interp_reg) && !frozen_reg;
    assign status.last_entry   = ({1'b0, e_reg} + 7'd1) == {1'b0, tsize_reg};

    assign result = result_reg;
    assign result_strobe = strobe_reg;
endmodule

/* design/spp_ctrl.sv */
// Controller: sequences the divides, the header and the delay entries of one move.
module spp_ctrl
    import spp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  dp_flags_t status,
    output cmd_t      cmd,
    output logic      busy
);
    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_A,
        S_CHECK,
        S_DIV_I,
        S_TS_START,
        S_DIV_T,
        S_HEADER,
        S_ENTRY,
        S_LOOP,
        S_REC_WAIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd        = CMD_LOAD;
                    state_next = S_DIV_A;
                end
            end
            S_DIV_A:
            begin
                if (status.div_done)
                begin
                    cmd        = CMD_SHAPE;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.need_enlarge)
                begin
                    cmd        = CMD_INTERP_DIV;
                    state_next = S_DIV_I;
                end
                else
                begin
                    cmd        = CMD_TSIZE_DIV;
                    state_next = S_DIV_T;
                end
            end
            S_DIV_I:
            begin
                cmd        = CMD_INTERP_SET;
                state_next = S_TS_START;
            end
            S_TS_START:
            begin
                cmd        = CMD_TSIZE_DIV;
                state_next = S_DIV_T;
            end
            S_DIV_T:
            begin
                if (status.div_done)
                begin
                    cmd        = CMD_TSIZE_SET;
                    state_next = S_HEADER;
                end
            end
            S_HEADER:
            begin
                cmd        = CMD_HEADER;
                state_next = status.tsize_zero ? S_IDLE : S_ENTRY;
            end
            S_ENTRY:
            begin
                cmd        = CMD_ENTRY;
                state_next = status.last_entry ? S_IDLE : S_LOOP;
            end
            S_LOOP:
            begin
                if (status.more_steps)
                begin
                    cmd        = CMD_REC_DIV;
                    state_next = S_REC_WAIT;
                end
                else
                begin
                    cmd        = CMD_NEXT_ENTRY;
                    state_next = S_ENTRY;
                end
            end
            S_REC_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd        = CMD_REC_UPD;
                    state_next = S_LOOP;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = state_reg != S_IDLE;
endmodule

/* design/stepper_accel_profile_planner.sv */
// Top level of the stepper acceleration profile planner.
//
// Usage: load the six registers over cfg_valid/cfg_ready (cfg_index selects
// the register, cfg_data carries the value; cfg_ready is always high), then
// raise start with a move item while busy is low. The item is taken at that
// edge and busy stays high until the move is fully emitted.
// Results appear on result with result_strobe for one cycle each: first the
// header, then one delay entry per table row; last marks the final item.
// The receiver cannot stall; every result must be taken as it appears.
// One shared serial divider performs every divide (DW is the larger of 34 and
// SCALE_BITS + 20 bits). The header follows the ramp and table-size divides,
// with extra reciprocal-multiply steps when the interpolation factor is enlarged.
// Each recurrence step then needs one divide, and each entry adds the states that
// emit it and advance the index; the recurrence stops early once the delay freezes.
// One move at a time; busy drops in the cycle that carries the last result.
// Reset clears the controller to idle and loads the register defaults.
module stepper_accel_profile_planner
    import spp_pkg::*;
#(
    parameter int TABLE_MAX = 32,
    parameter int SCALE_BITS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  item_t                 item,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  result_strobe,
    output result_t               result
);
    cmd_t      cmd;
    dp_flags_t status;

    assign cfg_ready = 1'b1;

    spp_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    spp_datapath #(
        .TABLE_MAX  (TABLE_MAX),
        .SCALE_BITS (SCALE_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .item          (item),
        .cmd           (cmd),
        .status        (status),
        .result        (result),
        .result_strobe (result_strobe)
    );

`ifndef SYNTHESIS
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted item");
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && result.last |=> !result_strobe)
        else $error("result after last item of a move");
    a_entry_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && result.kind == KIND_ENTRY |-> result.entry_index < result.table_size)
        else $error("entry index beyond table size");
`endif
endmodule

/* bench/stepper_accel_profile_planner_test.sv */
// Self-checking testbench for the stepper acceleration profile planner.
`timescale 1ns / 100ps

module stepper_accel_profile_planner_test;
    import spp_pkg::*;

    localparam int TABLE_MAX = 32;
    localparam int SCALE_BITS = 8;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 400;

    typedef struct {
        logic [31:0] total;
        logic        dir;
        bit          typed;
        result_t     hdr;
    } move_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    item_t                 item;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  result_strobe;
    result_t               result;

    logic [15:0] cur_velocity;
    logic [23:0] cur_accel;
    logic [15:0] cur_first_delay;
    logic [15:0] cur_min_delay;
    logic [7:0]  cur_base_interp;
    logic        cur_dir_high_cw;

    result_t     pending_results[$];
    int          error_count;
    int          moves_sent;
    int          results_seen;
    int          config_writes;
    int          idle_cycles;
    move_row_t   directed_moves[$];

    stepper_accel_profile_planner #(
        .TABLE_MAX(TABLE_MAX),
        .SCALE_BITS(SCALE_BITS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .item(item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .result_strobe(result_strobe),
        .result(result)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("MISMATCH result %0d field %s: got %0h expected %0h",
                 results_seen, field, got, want);
    endtask

    task automatic plan_move(input logic [31:0] total, input logic dir);
        logic [63:0] acc;
        logic [63:0] ramp;
        logic [63:0] up;
        logic [63:0] interp;
        logic [63:0] tsize;
        logic [63:0] cur;
        logic [63:0] floor_d;
        logic [63:0] k;
        logic [63:0] dec;
        logic [63:0] nx;
        logic [63:0] i;
        bit          frozen;
        result_t     r;
        begin
            frozen = 0;
            acc = (cur_accel == 0) ? 64'd1 : 64'(cur_accel);
            ramp = (64'(cur_velocity) * 64'(cur_velocity)) / (2 * acc);
            r = '0;
            r.kind = KIND_HEADER;
            if (ramp * 2 >= 64'(total))
            begin
                r.is_trapezoidal = 1'b0;
                up = 64'(total) / 2;
                r.accel_steps = up[31:0];
                r.decel_steps = total - up[31:0];
                r.cruise_steps = '0;
            end
            else
            begin
                r.is_trapezoidal = 1'b1;
                up = ramp;
                r.accel_steps = ramp[31:0];
                r.decel_steps = ramp[31:0];
                r.cruise_steps = total - 32'(2 * ramp);
            end
            interp = (cur_base_interp == 0) ? 64'd1 : 64'(cur_base_interp);
            if (up > TABLE_MAX * interp)
                interp = (up + TABLE_MAX - 1) / TABLE_MAX;
            tsize = (up + interp - 1) / interp;
            if (tsize > TABLE_MAX)
                tsize = TABLE_MAX;
            r.interp_factor = interp[31:0];
            r.table_size = tsize[TSIZE_W-1:0];
            r.dir_level = cur_dir_high_cw ? (dir == 1'b0) : (dir == 1'b1);
            r.last = (tsize == 0);
            pending_results.push_back(r);
            cur = 64'(cur_first_delay) << SCALE_BITS;
            floor_d = 64'(cur_min_delay) << SCALE_BITS;
            k = 1;
            for (int e = 0; e < tsize; e++)
            begin
                r.kind = KIND_ENTRY;
                r.entry_index = e[TSIZE_W-1:0];
                r.delay_ticks = 16'(cur >> SCALE_BITS);
                r.last = (e + 1 == tsize);
                pending_results.push_back(r);
                for (i = 0; i < interp && !frozen; i++)
                begin
                    dec = (2 * cur) / (4 * k + 1);
                    nx = cur - dec;
                    if (nx < floor_d)
                        nx = floor_d;
                    if (nx == cur && (dec == 0 || cur == floor_d))
                        frozen = 1;
                    cur = nx;
                    k++;
                end
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        begin
            @(negedge clk);
            cfg_valid = 1'b1;
            cfg_index = idx;
            cfg_data = data;
            @(negedge clk);
            while (!cfg_ready)
                @(negedge clk);
            cfg_valid = 1'b0;
            config_writes++;
            case (idx)
                REG_END_VELOCITY: cur_velocity = data[15:0];
                REG_ACCELERATION: cur_accel = data[23:0];
                REG_FIRST_DELAY:  cur_first_delay = data[15:0];
                REG_MIN_DELAY:    cur_min_delay = data[15:0];
                REG_BASE_INTERP:  cur_base_interp = data[7:0];
                REG_DIR_HIGH_CW:  cur_dir_high_cw = data[0];
                default: ;
            endcase
        end
    endtask

    task automatic wait_drained();
        begin
            while (pending_results.size() != 0)
                @(negedge clk);
            repeat (DRAIN_CYCLES) @(negedge clk);
        end
    endtask

    task automatic load_profile(input logic [15:0] vel, input logic [23:0] acc,
                                input logic [15:0] first, input logic [15:0] floor_t,
                                input logic [7:0] base, input logic cw);
        begin
            wait_drained();
            write_reg(REG_END_VELOCITY, 24'(vel));
            write_reg(REG_ACCELERATION, acc);
            write_reg(REG_FIRST_DELAY, 24'(first));
            write_reg(REG_MIN_DELAY, 24'(floor_t));
            write_reg(REG_BASE_INTERP, 24'(base));
            write_reg(REG_DIR_HIGH_CW, 24'(cw));
        end
    endtask

    task automatic send_move(input logic [31:0] total, input logic dir,
                             input int idle_pct, input bit typed, input result_t hdr);
        begin
            while ($urandom_range(99) < idle_pct)
            begin
                idle_cycles++;
                @(negedge clk);
            end
            while (busy)
                @(negedge clk);
            start = 1'b1;
            item.total_steps = total;
            item.direction = dir;
            if (typed)
                pending_results.push_back(hdr);
            else
                plan_move(total, dir);
            moves_sent++;
            @(negedge clk);
            start = 1'b0;
        end
    endtask

    task automatic random_moves(input int count, input int idle_pct, input bit wide,
                                input bit hold_mid);
        logic [31:0] total;
        begin
            for (int n = 0; n < count; n++)
            begin
                if (hold_mid && n == count / 2)
                    while (pending_results.size() != 0)
                        @(negedge clk);
                if (wide || $urandom_range(7) == 0)
                    total = $urandom;
                else
                    total = $urandom_range(1200);
                send_move(total, 1'($urandom_range(1)), idle_pct, 0, '0);
            end
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_strobe)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("UNEXPECTED result %0d with nothing pending", results_seen);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.kind != want.kind)
                    report_mismatch("kind", 32'(result.kind), 32'(want.kind));
                if (result.is_trapezoidal != want.is_trapezoidal)
                    report_mismatch("is_trapezoidal", 32'(result.is_trapezoidal),
                                    32'(want.is_trapezoidal));
                if (result.accel_steps != want.accel_steps)
                    report_mismatch("accel_steps", result.accel_steps, want.accel_steps);
                if (result.cruise_steps != want.cruise_steps)
                    report_mismatch("cruise_steps", result.cruise_steps, want.cruise_steps);
                if (result.decel_steps != want.decel_steps)
                    report_mismatch("decel_steps", result.decel_steps, want.decel_steps);
                if (result.interp_factor != want.interp_factor)
                    report_mismatch("interp_factor", result.interp_factor,
                                    want.interp_factor);
                if (result.table_size != want.table_size)
                    report_mismatch("table_size", 32'(result.table_size),
                                    32'(want.table_size));
                if (result.dir_level != want.dir_level)
                    report_mismatch("dir_level", 32'(result.dir_level), 32'(want.dir_level));
                if (result.entry_index != want.entry_index)
                    report_mismatch("entry_index", 32'(result.entry_index),
                                    32'(want.entry_index));
                if (result.delay_ticks != want.delay_ticks)
                    report_mismatch("delay_ticks", 32'(result.delay_ticks),
                                    32'(want.delay_ticks));
                if (result.last != want.last)
                    report_mismatch("last", 32'(result.last), 32'(want.last));
            end
        end
    end

    always @(posedge clk)
    begin
        int quiet;
        if (!rst_n || result_strobe || (start && !busy) || (cfg_valid && cfg_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog expired with %0d results pending", pending_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        move_row_t row;
        result_t   h;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        error_count = 0;
        moves_sent = 0;
        results_seen = 0;
        config_writes = 0;
        idle_cycles = 0;
        cur_velocity = 16'd1000;
        cur_accel = 24'd1000;
        cur_first_delay = 16'd65535;
        cur_min_delay = 16'd1000;
        cur_base_interp = 8'd1;
        cur_dir_high_cw = 1'b1;

        h = '0;
        h.kind = KIND_HEADER;
        h.interp_factor = 32'd1;
        h.dir_level = 1'b1;
        h.last = 1'b1;
        directed_moves.push_back('{32'd0, 1'b0, 1, h});
        h.decel_steps = 32'd1;
        h.dir_level = 1'b0;
        directed_moves.push_back('{32'd1, 1'b1, 1, h});
        foreach (directed_moves[i]) ;
        directed_moves.push_back('{32'd2, 1'b0, 0, '0});
        directed_moves.push_back('{32'd3, 1'b1, 0, '0});
        directed_moves.push_back('{32'd64, 1'b0, 0, '0});
        directed_moves.push_back('{32'd999, 1'b1, 0, '0});
        directed_moves.push_back('{32'd1000, 1'b0, 0, '0});
        directed_moves.push_back('{32'd1001, 1'b1, 0, '0});
        directed_moves.push_back('{32'h8000_0000, 1'b0, 0, '0});
        directed_moves.push_back('{32'hFFFF_FFFF, 1'b1, 0, '0});

        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_moves[i])
        begin
            row = directed_moves[i];
            send_move(row.total, row.dir, 0, row.typed, row.hdr);
        end

        load_profile(16'd65535, 24'd1, 16'd500, 16'd500, 8'd255, 1'b0);
        random_moves(16, 0, 1, 0);
        load_profile(16'd1, 24'hFF_FFFF, 16'd65535, 16'd65535, 8'd1, 1'b1);
        random_moves(16, 82, 1, 0);
        load_profile(16'd30, 24'd0, 16'd100, 16'd5000, 8'd0, 1'b0);
        random_moves(16, 10, 0, 0);
        for (int p = 0; p < 3; p++)
        begin
            logic [15:0] first;
            first = 16'($urandom_range(65535, 1));
            load_profile(16'($urandom_range(1000, 1)), 24'($urandom_range(24'hFF_FFFF, 1000)),
                         first, 16'(first / 8 + $urandom_range(100) + 1),
                         8'($urandom_range(255)), 1'($urandom_range(1)));
            random_moves(16, (p == 1) ? 82 : ((p == 2) ? 10 : 0), 0, p == 0);
        end

        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Ran %0d moves with %0d results checked over %0d register writes",
                 moves_sent, results_seen, config_writes);
        $display("Profiles covered triangular, trapezoidal, clamped and idle-gapped moves");
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
